>>> sv/rbp_pkg.sv
// Shared constants and types for the replicate border pad block.
package rbp_pkg;

	localparam int CFG_W          = 13;
	localparam int PAD_W          = 3;
	localparam int COORD_W        = 13;
	localparam int IDX_W          = 2;
	localparam int MAX_DIM_DEF    = 4096;
	localparam int PAD_MAX_DEF    = 7;
	localparam int PIXEL_BITS_DEF = 32;
	localparam int MAX_RESULTS    = 64;
	localparam int CNT_W          = $clog2(MAX_RESULTS);
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_PAD_SIZE   = 2'd2;

	localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd64;
	localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd64;
	localparam logic [PAD_W-1:0] PAD_SIZE_RST   = 3'd1;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x_lo;
		coord_t x_hi;
		coord_t y_lo;
		coord_t y_hi;
	} span_t;

endpackage

>>> sv/replicate_border_pad.sv
// Top level: configuration registers and the front, queue and back ends of the border pad.
// Path of a pixel: span queue, then the back end's span register, then the result register.
// Throughput: one result beat per cycle unless stalled; an inner pixel gives 1 result,
// edge pixels pad_size+1 and corner pixels up to 64 as the back end walks each span.
// A 4-entry span queue lets pixels keep arriving while a border run is being written out.
// Reset: width and height 64, pad 1, position counters at zero, queue and outputs empty.
module replicate_border_pad import rbp_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int PAD_MAX    = PAD_MAX_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  logic [PIXEL_BITS-1:0] pixel_value,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [COORD_W-1:0]    out_x,
	output logic [COORD_W-1:0]    out_y,
	output logic [PIXEL_BITS-1:0] out_value,
	output logic                  last_of_run
);

	localparam int QW = $bits(span_t) + PIXEL_BITS;

	logic [CFG_W-1:0]      src_width_q;
	logic [CFG_W-1:0]      src_height_q;
	logic [PAD_W-1:0]      pad_size_q;
	logic                  push;
	span_t                 push_span;
	logic [PIXEL_BITS-1:0] push_value;
	logic                  queue_full;
	logic                  head_valid;
	logic [QW-1:0]         head_data;
	span_t                 head_span;
	logic [PIXEL_BITS-1:0] head_value;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
			pad_size_q   <= PAD_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				REG_PAD_SIZE:   pad_size_q   <= cfg_data[PAD_W-1:0];
				default:        ;
			endcase
		end
	end

	rbp_front #(
		.MAX_DIM    (MAX_DIM),
		.PAD_MAX    (PAD_MAX),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_width   (src_width_q),
		.src_height  (src_height_q),
		.pad_size    (pad_size_q),
		.pixel_valid (pixel_valid),
		.pixel_value (pixel_value),
		.queue_full  (queue_full),
		.pixel_stall (pixel_stall),
		.push        (push),
		.push_span   (push_span),
		.push_value  (push_value)
	);

	rbp_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_span, push_value}),
		.pop        (pop),
		.head_data  (head_data),
		.head_valid (head_valid),
		.full       (queue_full)
	);

	assign head_span  = head_data[QW-1:PIXEL_BITS];
	assign head_value = head_data[PIXEL_BITS-1:0];

	rbp_back #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_span    (head_span),
		.head_value   (head_value),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_value    (out_value),
		.last_of_run  (last_of_run)
	);

endmodule

>>> sv/rbp_front.sv
// Front end: tracks the source position and classifies each pixel into an output span.
module rbp_front import rbp_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int PAD_MAX    = PAD_MAX_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CFG_W-1:0]      src_width,
	input  logic [CFG_W-1:0]      src_height,
	input  logic [PAD_W-1:0]      pad_size,
	input  logic                  pixel_valid,
	input  logic [PIXEL_BITS-1:0] pixel_value,
	input  logic                  queue_full,
	output logic                  pixel_stall,
	output logic                  push,
	output span_t                 push_span,
	output logic [PIXEL_BITS-1:0] push_value
);

	localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CMP_W = (POS_W + 1 > CFG_W) ? POS_W + 1 : CFG_W;

	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [CMP_W-1:0] w_eff;
	logic [CMP_W-1:0] h_eff;
	logic [PAD_W-1:0] p_eff;
	logic             last_col;
	logic             last_row;
	coord_t           col_c;
	coord_t           row_c;
	coord_t           pad_c;

	always_comb begin
		if (src_width == '0) begin
			w_eff = CMP_W'(1);
		end else if (CMP_W'(src_width) > CMP_W'(MAX_DIM)) begin
			w_eff = CMP_W'(MAX_DIM);
		end else begin
			w_eff = CMP_W'(src_width);
		end
		if (src_height == '0) begin
			h_eff = CMP_W'(1);
		end else if (CMP_W'(src_height) > CMP_W'(MAX_DIM)) begin
			h_eff = CMP_W'(MAX_DIM);
		end else begin
			h_eff = CMP_W'(src_height);
		end
		p_eff = (pad_size > PAD_W'(PAD_MAX)) ? PAD_W'(PAD_MAX) : pad_size;
	end

	assign last_col = CMP_W'(col_q) >= (w_eff - CMP_W'(1));
	assign last_row = CMP_W'(row_q) >= (h_eff - CMP_W'(1));
	assign col_c    = coord_t'(col_q);
	assign row_c    = coord_t'(row_q);
	assign pad_c    = coord_t'(p_eff);

	always_comb begin
		push_span.x_lo = (col_q == '0) ? '0 : col_c + pad_c;
		push_span.x_hi = last_col ? col_c + (pad_c << 1) : col_c + pad_c;
		push_span.y_lo = (row_q == '0) ? '0 : row_c + pad_c;
		push_span.y_hi = last_row ? row_c + (pad_c << 1) : row_c + pad_c;
	end

	assign pixel_stall = queue_full;
	assign push        = pixel_valid && !queue_full;
	assign push_value  = pixel_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

endmodule

>>> sv/rbp_queue.sv
// Short queue of classified spans between the front and back ends.
module rbp_queue import rbp_pkg::*; #(
	parameter int WIDTH = $bits(span_t) + PIXEL_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             head_valid,
	output logic             full
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = count_q == (PTR_W + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/rbp_back.sv
// Back end: walks each span row by row and drives the result register.
module rbp_back import rbp_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  span_t                 head_span,
	input  logic [PIXEL_BITS-1:0] head_value,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [COORD_W-1:0]    out_x,
	output logic [COORD_W-1:0]    out_y,
	output logic [PIXEL_BITS-1:0] out_value,
	output logic                  last_of_run
);

	logic                  cur_valid_q;
	span_t                 cur_span_q;
	logic [PIXEL_BITS-1:0] cur_value_q;
	coord_t                cur_x_q;
	coord_t                cur_y_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  result_valid_q;
	coord_t                out_x_q;
	coord_t                out_y_q;
	logic [PIXEL_BITS-1:0] out_value_q;
	logic                  last_q;
	logic                  emit;
	logic                  emit_last;
	logic                  row_end;

	assign emit      = cur_valid_q && (!result_valid_q || !result_stall);
	assign row_end   = cur_x_q == cur_span_q.x_hi;
	assign emit_last = (row_end && cur_y_q == cur_span_q.y_hi)
	                || (cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign pop       = head_valid && (!cur_valid_q || (emit && emit_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q    <= 1'b0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (emit && emit_last) begin
				cur_valid_q <= 1'b0;
			end
			if (pop || (emit && emit_last)) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_span_q  <= head_span;
			cur_value_q <= head_value;
			cur_x_q     <= head_span.x_lo;
			cur_y_q     <= head_span.y_lo;
		end else if (emit) begin
			if (row_end) begin
				cur_x_q <= cur_span_q.x_lo;
				cur_y_q <= cur_y_q + COORD_W'(1);
			end else begin
				cur_x_q <= cur_x_q + COORD_W'(1);
			end
		end
		if (emit) begin
			out_x_q     <= cur_x_q;
			out_y_q     <= cur_y_q;
			out_value_q <= cur_value_q;
			last_q      <= emit_last;
		end
	end

	assign result_valid = result_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_value    = out_value_q;
	assign last_of_run  = last_q;

	a_last_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (cnt_q == '0))
		else $error("run count not cleared after last beat");

	a_load_starts_corner: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (cur_x_q == $past(head_span.x_lo) && cur_y_q == $past(head_span.y_lo)))
		else $error("span not started at its first position");

	a_no_pop_midrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_valid_q && !(emit && emit_last)) |-> !pop)
		else $error("span loaded while a run is in progress");

endmodule
